>>> rtl/asls_pkg.sv
// Package: mode and event codes, register indexes, widths and reset values for the alarm sequencer.
`default_nettype none
package asls_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_RINGING   = 3'd1,
    MODE_STEADY    = 3'd2,
    MODE_SETTING   = 3'd3,
    MODE_RESETTING = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_SET_RISE     = 3'd1,
    EV_SET_FALL     = 3'd2,
    EV_RESET        = 3'd3,
    EV_MANUAL_SET   = 3'd4,
    EV_MANUAL_RESET = 3'd5
  } event_t;

  localparam int unsigned REG_W = 16;
  localparam int unsigned IN_W  = 8;
  localparam int unsigned OUT_W = 8;

  localparam logic REG_TOGGLE_PERIOD  = 1'b0;
  localparam logic REG_FLASH_DURATION = 1'b1;

  localparam logic [REG_W-1:0] TOGGLE_PERIOD_RESET  = 16'd500;
  localparam logic [REG_W-1:0] FLASH_DURATION_RESET = 16'd2000;

endpackage
`default_nettype wire

>>> rtl/alarm_siren_lamp_sequencer.sv
// Alarm sequencer: configuration registers, event priority, mode machine, blink timers and result register.
// Latency: the result of an item is valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the state update and result register are a single
// registered pass, and s_tready stays high while the result register is empty or taken.
// Reset (rst, synchronous): mode idle, lamp and siren off, both elapsed counters zero,
// toggle period 500 and flash duration 2000, no result pending.
`default_nettype none
module alarm_siren_lamp_sequencer #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  output logic                        s_tready,
  // bit 0 set_rise, 1 set_fall, 2 reset_input_rise, 3 manual_set_rise,
  // 4 manual_reset_rise, 7:5 zero
  input  wire  [asls_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  wire                         m_tready,
  // bit 0 lamp_level, 1 siren_level, 4:2 mode_now, 7:5 zero
  output logic [asls_pkg::OUT_W-1:0]  m_tdata,
  input  wire                         cfg_we,
  input  wire                         cfg_index,
  input  wire  [asls_pkg::REG_W-1:0]  cfg_data
);
  import asls_pkg::*;

  localparam int unsigned CMP_W = (TIMER_BITS > REG_W) ? TIMER_BITS : REG_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic [REG_W-1:0]      toggle_period;
  logic [REG_W-1:0]      flash_duration;
  mode_t                 mode, mode_next;
  logic [TIMER_BITS-1:0] toggle_elapsed, toggle_elapsed_next;
  logic [TIMER_BITS-1:0] flash_elapsed, flash_elapsed_next;
  logic                  lamp_bit, lamp_bit_next;
  logic                  siren_bit, siren_bit_next;

  event_t                ev;
  logic [TIMER_BITS-1:0] toggle_inc, flash_inc;
  logic                  toggle_due, flash_due;
  logic                  accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      toggle_period  <= TOGGLE_PERIOD_RESET;
      flash_duration <= FLASH_DURATION_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_TOGGLE_PERIOD) toggle_period <= cfg_data;
      if (cfg_index == REG_FLASH_DURATION) flash_duration <= cfg_data;
    end
  end

  // pick the highest-priority flag
  always_comb begin
    if (s_tdata[0])      ev = EV_SET_RISE;
    else if (s_tdata[1]) ev = EV_SET_FALL;
    else if (s_tdata[2]) ev = EV_RESET;
    else if (s_tdata[3]) ev = EV_MANUAL_SET;
    else if (s_tdata[4]) ev = EV_MANUAL_RESET;
    else                 ev = EV_NONE;
  end

  // advance the counters, holding at full scale
  assign toggle_inc = (toggle_elapsed == TIMER_MAX) ? TIMER_MAX : toggle_elapsed + 1'b1;
  assign flash_inc  = (flash_elapsed == TIMER_MAX) ? TIMER_MAX : flash_elapsed + 1'b1;

  assign toggle_due = CMP_W'(toggle_inc) >= CMP_W'(toggle_period);
  assign flash_due  = CMP_W'(flash_inc) >= CMP_W'(flash_duration);

  always_comb begin
    mode_next           = mode;
    toggle_elapsed_next = toggle_inc;
    flash_elapsed_next  = flash_inc;
    lamp_bit_next       = lamp_bit;
    siren_bit_next      = siren_bit;
    unique case (mode)
      MODE_IDLE: begin
        if (ev == EV_MANUAL_SET) begin
          toggle_elapsed_next = '0;
          flash_elapsed_next  = '0;
          mode_next           = MODE_SETTING;
        end else if (ev == EV_SET_RISE) begin
          siren_bit_next      = 1'b1;
          lamp_bit_next       = 1'b1;
          toggle_elapsed_next = '0;
          mode_next           = MODE_RINGING;
        end
      end
      MODE_RINGING: begin
        if (ev == EV_SET_FALL) begin
          siren_bit_next = 1'b0;
          mode_next      = MODE_STEADY;
        end else if (toggle_due) begin
          toggle_elapsed_next = '0;
          siren_bit_next      = !siren_bit;
        end
      end
      MODE_STEADY: begin
        if (ev == EV_MANUAL_RESET || ev == EV_RESET) begin
          toggle_elapsed_next = '0;
          flash_elapsed_next  = '0;
          siren_bit_next      = 1'b1;
          mode_next           = MODE_RESETTING;
        end
      end
      MODE_SETTING: begin
        if (flash_due) begin
          lamp_bit_next  = 1'b1;
          siren_bit_next = 1'b0;
          mode_next      = MODE_STEADY;
        end else if (toggle_due) begin
          toggle_elapsed_next = '0;
          siren_bit_next      = !siren_bit;
        end
      end
      MODE_RESETTING: begin
        if (toggle_due) begin
          siren_bit_next = 1'b0;
          lamp_bit_next  = 1'b0;
          mode_next      = MODE_IDLE;
        end
      end
      default: begin
        mode_next      = MODE_IDLE;
        lamp_bit_next  = 1'b0;
        siren_bit_next = 1'b0;
      end
    endcase
  end

  // state advances once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      toggle_elapsed <= '0;
      flash_elapsed  <= '0;
      lamp_bit       <= 1'b0;
      siren_bit      <= 1'b0;
    end else if (accept) begin
      mode           <= mode_next;
      toggle_elapsed <= toggle_elapsed_next;
      flash_elapsed  <= flash_elapsed_next;
      lamp_bit       <= lamp_bit_next;
      siren_bit      <= siren_bit_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, mode_next, siren_bit_next, lamp_bit_next};
    end
  end

  // mode and drive levels stay consistent
  a_idle_dark: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDLE) |-> (!lamp_bit && !siren_bit))
    else $error("idle with lamp or siren on");

  a_lamp_lit: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_RINGING || mode == MODE_STEADY) |-> lamp_bit)
    else $error("ringing or steady with lamp off");

  a_steady_quiet: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_STEADY) |-> !siren_bit)
    else $error("steady with siren on");

  a_resetting_siren: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_RESETTING) |-> siren_bit)
    else $error("resetting with siren off");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted item left no result");

endmodule
`default_nettype wire
